FILE: rtl/msws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msws_pkg
// Shared constants, types and the constant sine table for the multi-shape
// waveform sequencer.
// ----------------------------------------------------------------------------
package msws_pkg;

  localparam int TableSize       = 256;
  localparam int FullScaleLevels = 1000;
  localparam int LevelMax        = FullScaleLevels - 1;
  localparam int LedDivide       = 100;

  localparam int IdxW   = $clog2(TableSize);
  localparam int DutyW  = 10;
  localparam int CountW = 32;
  localparam int LevelW = $clog2(FullScaleLevels);
  localparam int ModW   = $clog2(LedDivide);

  localparam real Pi = 3.14159265358979323846;

  typedef enum logic [1:0] {
    SHAPE_SINE        = 2'd0,
    SHAPE_TRIANGLE    = 2'd1,
    SHAPE_SAWTOOTH    = 2'd2,
    SHAPE_SOFT_SQUARE = 2'd3
  } shape_t;

  typedef struct packed {
    logic              half_done;
    logic              cycle_done;
    logic [CountW-1:0] full_cycles;
    logic [CountW-1:0] half_cycles;
    logic              led_level;
  } status_t;

  typedef logic [DutyW-1:0] sine_rom_t [TableSize];

  function automatic logic [DutyW-1:0] sine_sample(input int i);
    int  q;
    int  m;
    bit  neg;
    real s;
    real v;
    q = 4 * i;
    if (q <= TableSize) begin
      m   = q;
      neg = 1'b0;
    end else if (q <= 2 * TableSize) begin
      m   = 2 * TableSize - q;
      neg = 1'b0;
    end else if (q <= 3 * TableSize) begin
      m   = q - 2 * TableSize;
      neg = 1'b1;
    end else begin
      m   = 4 * TableSize - q;
      neg = 1'b1;
    end
    if (m == 0) begin
      s = 0.0;
    end else if (m >= TableSize) begin
      s = 1.0;
    end else if (3 * m == TableSize) begin
      s = 0.5;
    end else begin
      s = $sin(Pi / 2.0 * m / TableSize);
    end
    v = neg ? (1.0 - s) : (1.0 + s);
    return DutyW'($rtoi(v * LevelMax / 2.0));
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < TableSize; i++) begin
      rom[i] = sine_sample(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage
`default_nettype wire

FILE: rtl/msws_shape.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msws_shape
// Duty value of the selected shape at one sample index: sine table lookup or
// one scaled ramp segment.
// ----------------------------------------------------------------------------
module msws_shape (
  input  wire msws_pkg::shape_t         shape,
  input  wire logic [msws_pkg::IdxW-1:0]  idx,
  output logic      [msws_pkg::DutyW-1:0] duty
);
  import msws_pkg::*;

  localparam int OperandW  = $clog2(20 * TableSize + 1);
  localparam int ProdW     = OperandW + LevelW;
  localparam int ScaleSh   = IdxW + 1;
  localparam int RampSlope = 20;

  logic [OperandW-1:0] idx_w;
  logic [OperandW-1:0] i20;
  logic [OperandW-1:0] operand;
  logic [ProdW-1:0]    product;
  logic [DutyW-1:0]    scaled;

  assign idx_w   = OperandW'(idx);
  assign i20     = idx_w * OperandW'(RampSlope);
  assign product = ProdW'(operand) * ProdW'(LevelMax);
  assign scaled  = DutyW'(product >> ScaleSh);

  // all ramps share one scale: value = operand * M / (2N)
  always_comb begin
    operand = '0;
    duty    = scaled;
    case (shape)
      SHAPE_SINE: begin
        duty = SineRom[idx];
      end
      SHAPE_TRIANGLE: begin
        if (idx[IdxW-1]) begin
          operand = (OperandW'(TableSize) - idx_w) << 2;
        end else begin
          operand = idx_w << 2;
        end
      end
      SHAPE_SAWTOOTH: begin
        operand = idx_w << 1;
      end
      default: begin
        if (i20 < OperandW'(2 * TableSize)) begin
          operand = i20;
        end else if (i20 < OperandW'(9 * TableSize)) begin
          duty = DutyW'(LevelMax);
        end else if (i20 < OperandW'(11 * TableSize)) begin
          operand = OperandW'(11 * TableSize) - i20;
        end else if (i20 < OperandW'(18 * TableSize)) begin
          duty = '0;
        end else begin
          operand = i20 - OperandW'(18 * TableSize);
        end
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/msws_track.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msws_track
// Sample index, half and full cycle counters and indicator level, with the
// updated values for the transfer being taken.
// ----------------------------------------------------------------------------
module msws_track (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            advance,
  input  wire                            restart,
  output logic     [msws_pkg::IdxW-1:0]  idx,
  output msws_pkg::status_t              status
);
  import msws_pkg::*;

  logic [IdxW-1:0]   sample_index;
  logic [CountW-1:0] full_count;
  logic [CountW-1:0] half_count;
  logic [ModW-1:0]   led_mod;
  logic              led;

  logic [IdxW-1:0]   sample_index_next;
  logic [CountW-1:0] full_base;
  logic [CountW-1:0] half_base;
  logic [ModW-1:0]   mod_base;
  logic [CountW-1:0] full_count_next;
  logic [CountW-1:0] half_count_next;
  logic [ModW-1:0]   led_mod_next;
  logic              led_next;
  logic              half_hit;
  logic              full_hit;

  always_comb begin
    idx       = restart ? '0 : sample_index;
    full_base = restart ? '0 : full_count;
    half_base = restart ? '0 : half_count;
    mod_base  = restart ? '0 : led_mod;
    half_hit  = (idx == IdxW'(TableSize / 2 - 1));
    full_hit  = (idx == IdxW'(TableSize - 1));
    half_count_next = half_base + CountW'(half_hit);
    full_count_next = full_base + CountW'(full_hit);
    led_mod_next    = mod_base;
    // counter wrap lands on zero, which is a multiple of the divide too
    if (full_hit) begin
      if (&full_base) begin
        led_mod_next = '0;
      end else if (mod_base == ModW'(LedDivide - 1)) begin
        led_mod_next = '0;
      end else begin
        led_mod_next = mod_base + ModW'(1);
      end
    end
    led_next          = led ^ (full_hit && (led_mod_next == '0));
    sample_index_next = full_hit ? '0 : idx + IdxW'(1);
  end

  assign status = '{half_done:   half_hit,
                    cycle_done:  full_hit,
                    full_cycles: full_count_next,
                    half_cycles: half_count_next,
                    led_level:   led_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      full_count   <= '0;
      half_count   <= '0;
      led_mod      <= '0;
      led          <= 1'b1;
    end else if (advance) begin
      sample_index <= sample_index_next;
      full_count   <= full_count_next;
      half_count   <= half_count_next;
      led_mod      <= led_mod_next;
      led          <= led_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/multi_shape_waveform_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_shape_waveform_sequencer_top
// Table-based function generator: one PWM duty value per input transfer for
// sine, triangle, sawtooth or soft square, with half and full cycle counting.
// ----------------------------------------------------------------------------
// result: registered on the input transfer, valid in the following cycle
// throughput: one transfer per cycle while out_ready stays high; the result register frees as it drains
// the index, counters and shape math are combinational, ahead of the result register
// reset: shape sine, index and counters zero, indicator high, no result pending
module multi_shape_waveform_sequencer_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [1:0]                       cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              restart,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [msws_pkg::DutyW-1:0]       duty_value,
  output logic                             half_done,
  output logic                             cycle_done,
  output logic [msws_pkg::CountW-1:0]      full_cycles,
  output logic [msws_pkg::CountW-1:0]      half_cycles,
  output logic                             led_level
);
  import msws_pkg::*;

  shape_t           waveform_select;
  logic             accept;
  logic [IdxW-1:0]  idx;
  logic [DutyW-1:0] duty;
  status_t          status;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_select <= SHAPE_SINE;
    end else if (cfg_we) begin
      waveform_select <= shape_t'(cfg_wdata);
    end
  end

  msws_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .restart (restart),
    .idx     (idx),
    .status  (status)
  );

  msws_shape u_shape (
    .shape (waveform_select),
    .idx   (idx),
    .duty  (duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      duty_value  <= duty;
      half_done   <= status.half_done;
      cycle_done  <= status.cycle_done;
      full_cycles <= status.full_cycles;
      half_cycles <= status.half_cycles;
      led_level   <= status.led_level;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(half_done && cycle_done))
    else $error("half and full flags set together");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_value <= DutyW'(LevelMax)))
    else $error("duty value above full scale");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("transfer taken without a result");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && restart) |=> (full_cycles == '0 && half_cycles == '0 && !cycle_done))
    else $error("restart did not clear the counters");

  a_full_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && !restart && status.cycle_done) |=> (full_cycles != $past(full_cycles)))
    else $error("full cycle count did not advance");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-shape waveform sequencer. A transfer model
// built from integer and Q60 fixed-point math predicts every duty value, flag and
// counter; random burst/gap traffic and receiver stalls stress the handshake.
// ----------------------------------------------------------------------------
module tb_top;
  import msws_pkg::*;

  localparam bit [63:0] QOne      = 64'd1 << 60;
  localparam bit [63:0] HalfPiQ60 = 64'h1921FB54442D1846;
  localparam int        HoldCycles = 300;

  typedef struct {
    bit [DutyW-1:0]  duty;
    bit              half;
    bit              cyc;
    bit [CountW-1:0] full_cnt;
    bit [CountW-1:0] half_cnt;
    bit              led;
  } tick_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic             restart;
  logic             out_valid;
  logic             out_ready;
  logic [DutyW-1:0] duty_value;
  logic             half_done;
  logic             cycle_done;
  logic [CountW-1:0] full_cycles;
  logic [CountW-1:0] half_cycles;
  logic             led_level;

  // predictor state
  bit [DutyW-1:0]  sine_lut [TableSize];
  int unsigned     seq_index;
  bit [CountW-1:0] seq_full;
  bit [CountW-1:0] seq_half;
  bit              seq_led;
  shape_t          active_shape;

  tick_result_t    pending_samples [$];
  int              errors;
  int              n_sent;
  int              n_checked;
  int              led_flips;
  bit              last_led;
  bit [3:0]        shapes_used;

  // traffic control
  int              burst_left;
  bit              gapless;
  bit              rx_free;
  bit              hold_req;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multi_shape_waveform_sequencer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .duty_value  (duty_value),
    .half_done   (half_done),
    .cycle_done  (cycle_done),
    .full_cycles (full_cycles),
    .half_cycles (half_cycles),
    .led_level   (led_level)
  );

  function automatic bit [63:0] q60_mul(input bit [63:0] a, input bit [63:0] b);
    bit [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // sin(pi/2 * m / N) in Q60 by Taylor series
  function automatic bit [63:0] quarter_wave(input longint unsigned m);
    bit [127:0] num;
    bit [63:0]  f, x, x2, term, sum;
    int         k;
    bit         sub;
    if (m == 0) return 64'd0;
    if (m >= TableSize) return QOne;
    if (3 * m == TableSize) return QOne >> 1;
    num  = 128'(m) << 60;
    f    = 64'(num / TableSize);
    x    = q60_mul(HalfPiQ60, f);
    x2   = q60_mul(x, x);
    term = x;
    sum  = x;
    sub  = 1'b1;
    for (k = 1; k < 60 && term != 0; k += 2) begin
      term = q60_mul(term, x2) / 64'((k + 1) * (k + 2));
      sum  = sub ? sum - term : sum + term;
      sub  = !sub;
    end
    return (sum > QOne) ? QOne : sum;
  endfunction

  function automatic bit [DutyW-1:0] sine_point(input int unsigned i);
    longint unsigned q, m;
    bit              neg;
    bit [63:0]       s, f;
    bit [127:0]      p;
    q = 4 * longint'(i);
    if (q <= TableSize) begin
      m   = q;
      neg = 1'b0;
    end else if (q <= 2 * TableSize) begin
      m   = 2 * TableSize - q;
      neg = 1'b0;
    end else if (q <= 3 * TableSize) begin
      m   = q - 2 * TableSize;
      neg = 1'b1;
    end else begin
      m   = 4 * TableSize - q;
      neg = 1'b1;
    end
    s = quarter_wave(m);
    f = neg ? QOne - s : QOne + s;
    p = 128'(LevelMax) * 128'(f);
    return DutyW'(p >> 61);
  endfunction

  function automatic bit [DutyW-1:0] shape_level(input shape_t s, input int unsigned i);
    longint unsigned n, m, li, v;
    n  = TableSize;
    m  = LevelMax;
    li = i;
    case (s)
      SHAPE_SINE:     v = sine_lut[i];
      SHAPE_TRIANGLE: v = (2 * li < n) ? 2 * li * m / n : 2 * (n - li) * m / n;
      SHAPE_SAWTOOTH: v = li * m / n;
      default: begin
        if (10 * li < n) v = 10 * li * m / n;
        else if (20 * li < 9 * n) v = m;
        else if (20 * li < 11 * n) v = (11 * n - 20 * li) * m / (2 * n);
        else if (10 * li < 9 * n) v = 0;
        else v = (10 * li - 9 * n) * m / n;
      end
    endcase
    return DutyW'(v);
  endfunction

  function automatic tick_result_t advance_sequencer(input bit clear);
    tick_result_t r;
    if (clear) begin
      seq_index = 0;
      seq_full  = '0;
      seq_half  = '0;
    end
    r.duty = shape_level(active_shape, seq_index);
    r.half = (seq_index == TableSize / 2 - 1);
    r.cyc  = (seq_index == TableSize - 1);
    if (r.half) seq_half++;
    if (r.cyc) begin
      seq_full++;
      if (seq_full % LedDivide == 0) seq_led = !seq_led;
      seq_index = 0;
    end else begin
      seq_index++;
    end
    r.full_cnt = seq_full;
    r.half_cnt = seq_half;
    r.led      = seq_led;
    return r;
  endfunction

  // input side: predict on every accepted transfer
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_samples.push_back(advance_sequencer(restart));
      n_sent++;
    end
  end

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    errors++;
    if (errors <= 10)
      $display("tb_top: mismatch on %s at result %0d: expected %0d, got %0d",
               what, n_checked, want, got);
  endtask

  // output side: compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb_top: unexpected result %0d, duty %0d", n_checked, duty_value);
      end else begin
        want = pending_samples.pop_front();
        if (duty_value != want.duty) note_mismatch("duty_value", want.duty, duty_value);
        if (half_done != want.half) note_mismatch("half_done", want.half, half_done);
        if (cycle_done != want.cyc) note_mismatch("cycle_done", want.cyc, cycle_done);
        if (full_cycles != want.full_cnt)
          note_mismatch("full_cycles", want.full_cnt, full_cycles);
        if (half_cycles != want.half_cnt)
          note_mismatch("half_cycles", want.half_cnt, half_cycles);
        if (led_level != want.led) note_mismatch("led_level", want.led, led_level);
      end
      if (led_level != last_led) led_flips++;
      last_led = led_level;
      n_checked++;
    end
  end

  // receiver: changing stall pattern, plus a long hold-off on request
  initial begin : receiver
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        if (rx_free || mode == 0) out_ready <= 1'b1;
        else if (mode == 1) out_ready <= 1'($urandom_range(0, 1));
        else out_ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic send_tick(input bit clear);
    int gap;
    if (!gapless && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    restart  <= clear;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_shape(input shape_t s);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we       <= 1'b0;
    active_shape = s;
    shapes_used[s] = 1'b1;
  endtask

  task automatic test_reset_state();
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
  endtask

  // shape change keeps index and counters
  task automatic test_shape_change();
    write_shape(SHAPE_SOFT_SQUARE);
    repeat (3) send_tick(1'b0);
    write_shape(SHAPE_SINE);
    repeat (3) send_tick(1'b0);
    write_shape(SHAPE_TRIANGLE);
    repeat (3) send_tick(1'b0);
    write_shape(SHAPE_SAWTOOTH);
    repeat (3) send_tick(1'b0);
  endtask

  // every index of every shape, through half and wrap
  task automatic test_shape_sweep();
    int s;
    for (s = 0; s < 4; s++) begin
      write_shape(shape_t'(s));
      send_tick(1'b1);
      repeat (TableSize + 3) send_tick(1'b0);
    end
  endtask

  task automatic test_backpressure();
    int k;
    drain_results();
    hold_req = 1'b1;
    for (k = 0; k < 24; k++) send_tick($urandom_range(0, 15) == 0);
    wait (!hold_req);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int ph;
    int k;
    int rate;
    for (ph = 0; ph < 5; ph++) begin
      write_shape(shape_t'($urandom_range(0, 3)));
      rate = (ph == 2) ? 4 : 400;
      for (k = 0; k < 140; k++) send_tick($urandom_range(0, rate - 1) == 0);
    end
    drain_results();
  endtask

  // a full table back to back with the receiver always ready, then a restart
  task automatic test_back_to_back();
    write_shape(SHAPE_SAWTOOTH);
    gapless = 1'b1;
    rx_free = 1'b1;
    send_tick(1'b1);
    repeat (TableSize - 1) send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    gapless = 1'b0;
    rx_free = 1'b0;
    drain_results();
  endtask

  initial begin : main
    int i;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = SHAPE_SINE;
    in_valid     = 1'b0;
    restart      = 1'b0;
    errors       = 0;
    n_sent       = 0;
    n_checked    = 0;
    led_flips    = 0;
    last_led     = 1'b1;
    shapes_used  = 4'b0001;
    burst_left   = 0;
    gapless      = 1'b0;
    rx_free      = 1'b0;
    hold_req     = 1'b0;
    for (i = 0; i < TableSize; i++) sine_lut[i] = sine_point(i);
    seq_index    = 0;
    seq_full     = '0;
    seq_half     = '0;
    seq_led      = 1'b1;
    active_shape = SHAPE_SINE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_shape_change();
    test_shape_sweep();
    test_backpressure();
    test_random_traffic();
    test_back_to_back();

    drain_results();
    repeat (8) @(posedge clk);
    $display("tb_top: %0d transfers in, %0d results checked, shapes used %b",
             n_sent, n_checked, shapes_used);
    $display("tb_top: indicator flips seen %0d, mismatches %0d", led_flips, errors);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/msws_pkg.sv
rtl/msws_shape.sv
rtl/msws_track.sv
rtl/multi_shape_waveform_sequencer_top.sv
bench/tb_top.sv
